// File: src/lpg_pkg.sv
// lpg_pkg: shared types, constants and codes for the led pattern generator
// no dependencies; used by lpg_alu, led_pattern_generator and the testbench
package lpg_pkg;

   localparam int NumLedsDefault = 8;

   localparam int LevelW   = 16;
   localparam int FrameW   = 10;
   localparam int IndexW   = 8;
   localparam int ModeW    = 3;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam logic [LevelW-1:0] FullLevel = 16'hFFFF;

   localparam logic [FrameW-1:0] FrameMsReset     = 10'd20;
   localparam logic [LevelW-1:0] FastHalfMsReset  = 16'd100;
   localparam logic [LevelW-1:0] SlowHalfMsReset  = 16'd500;
   localparam logic [LevelW-1:0] OnceMsReset      = 16'd100;
   localparam logic [LevelW-1:0] BreatheStepReset = 16'd1311;

   localparam logic CmdTick = 1'b0;
   localparam logic CmdSet  = 1'b1;

   typedef enum logic [ModeW-1:0] {
      MODE_OFF     = 3'd0,
      MODE_ON      = 3'd1,
      MODE_FAST    = 3'd2,
      MODE_SLOW    = 3'd3,
      MODE_ONCE    = 3'd4,
      MODE_BREATHE = 3'd5
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_MS     = 3'd0,
      CSR_FAST_HALF_MS = 3'd1,
      CSR_SLOW_HALF_MS = 3'd2,
      CSR_ONCE_MS      = 3'd3,
      CSR_BREATHE_STEP = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BREATHE,
      ST_FAST_ADD,
      ST_FAST_CMP,
      ST_SLOW_ADD,
      ST_SLOW_CMP,
      ST_ONCE_ADD,
      ST_ONCE_CMP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD_SAT,
      ALU_SUB_FLOOR,
      ALU_CMP
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [LevelW-1:0] a;
      logic [LevelW-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [LevelW-1:0] res;
      logic              gt;
   } alu_rsp_type;

endpackage

// File: src/lpg_alu.sv
// lpg_alu: shared 16-bit saturating add / floored subtract / compare unit
// depends on lpg_pkg
module lpg_alu (
   input  lpg_pkg::alu_req_type req,
   output lpg_pkg::alu_rsp_type rsp
);

   logic [lpg_pkg::LevelW:0] sum;
   logic [lpg_pkg::LevelW:0] diff;
   logic                     gt;

   assign sum  = {1'b0, req.a} + {1'b0, req.b};
   assign diff = {1'b0, req.a} - {1'b0, req.b};
   // a > b: no borrow and a nonzero difference
   assign gt   = !diff[lpg_pkg::LevelW] && (diff[lpg_pkg::LevelW-1:0] != '0);

   always_comb begin
      rsp.gt = gt;
      unique case (req.op)
         lpg_pkg::ALU_ADD_SAT: begin
            rsp.res = sum[lpg_pkg::LevelW] ? lpg_pkg::FullLevel : sum[lpg_pkg::LevelW-1:0];
         end
         lpg_pkg::ALU_SUB_FLOOR: begin
            rsp.res = gt ? diff[lpg_pkg::LevelW-1:0] : '0;
         end
         lpg_pkg::ALU_CMP: begin
            rsp.res = diff[lpg_pkg::LevelW-1:0];
         end
         default: begin
            rsp.res = '0;
         end
      endcase
   end

endmodule

// File: src/led_pattern_generator.sv
// led_pattern_generator: top level, sequencer, led mode/level store, output register
// depends on lpg_pkg and lpg_alu
//
// Status LED controller. A set-mode item (req_cmd=1) answers with one item carrying
// the LED's new level (bad_index set for an index at or above NUM_LEDS). A frame tick
// (req_cmd=0) runs seven sequencer steps on one shared 16-bit add/compare unit
// (breathe duty, then add and compare for the fast, slow and one-shot timers), then
// emits NUM_LEDS items, one per cycle while rsp_ready is high, LED 0 first, last set
// on the final one. req_ready is low while a tick is in progress. Registers are
// written through the csr port, which is always ready; writes should be made while
// no tick is in progress.
module led_pattern_generator #(
   parameter int NUM_LEDS = lpg_pkg::NumLedsDefault
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [lpg_pkg::IndexW-1:0]     req_led_index,
   input  logic [lpg_pkg::ModeW-1:0]      req_mode,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpg_pkg::IndexW-1:0]     rsp_led_number,
   output logic [lpg_pkg::LevelW-1:0]     rsp_level,
   output logic                           rsp_last,
   output logic                           rsp_bad_index,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpg_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [lpg_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int LW   = lpg_pkg::LevelW;

   // configuration registers
   logic [lpg_pkg::FrameW-1:0] frame_ms_ff;
   logic [LW-1:0]              fast_half_ms_ff;
   logic [LW-1:0]              slow_half_ms_ff;
   logic [LW-1:0]              once_ms_ff;
   logic [LW-1:0]              breathe_step_ff;

   // per-led store
   lpg_pkg::mode_type          modes_ff [NUM_LEDS];
   logic [LW-1:0]              levels_ff [NUM_LEDS];

   // timers and sequencer
   lpg_pkg::state_type         state_ff, state_in;
   logic [IdxW-1:0]            cnt_ff, cnt_in;
   logic [LW-1:0]              duty_ff, duty_in;
   logic                       rising_ff, rising_in;
   logic [LW-1:0]              fast_accum_ff, fast_accum_in;
   logic [LW-1:0]              slow_accum_ff, slow_accum_in;
   logic [LW-1:0]              once_accum_ff, once_accum_in;
   logic                       fast_on_ff, fast_on_in;
   logic                       slow_on_ff, slow_on_in;
   logic                       once_on_ff, once_on_in;
   logic                       once_done_ff, once_done_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lpg_pkg::IndexW-1:0] rsp_num_ff, rsp_num_in;
   logic [LW-1:0]              rsp_level_ff, rsp_level_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_bad_ff, rsp_bad_in;

   // store write port
   logic                       mode_we;
   logic                       level_we;
   logic [IdxW-1:0]            wr_idx;
   lpg_pkg::mode_type          mode_wdata;
   logic [LW-1:0]              level_wdata;

   lpg_pkg::alu_req_type       alu_req;
   lpg_pkg::alu_rsp_type       alu_rsp;

   logic                       out_free;
   logic                       req_take;
   logic                       set_in_range;
   logic [IdxW-1:0]            set_idx;
   logic [LW-1:0]              set_level;
   logic [LW-1:0]              emit_level;
   logic                       cnt_at_last;

   lpg_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == lpg_pkg::ST_IDLE) && out_free;
   assign req_take     = req_valid && req_ready;
   assign csr_ready    = 1'b1;
   assign set_in_range = req_led_index < lpg_pkg::IndexW'(NUM_LEDS);
   assign set_idx      = req_led_index[IdxW-1:0];
   assign cnt_at_last  = cnt_ff == IdxW'(NUM_LEDS - 1);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_number = rsp_num_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_bad_index  = rsp_bad_ff;

   // level answered by a set-mode item
   always_comb begin
      unique case (req_mode)
         lpg_pkg::MODE_OFF:  set_level = '0;
         lpg_pkg::MODE_ON:   set_level = lpg_pkg::FullLevel;
         lpg_pkg::MODE_ONCE: set_level = lpg_pkg::FullLevel;
         default:            set_level = levels_ff[set_idx];
      endcase
   end

   // level of the led being emitted after the timers moved
   always_comb begin
      unique case (modes_ff[cnt_ff])
         lpg_pkg::MODE_OFF:     emit_level = '0;
         lpg_pkg::MODE_ON:      emit_level = lpg_pkg::FullLevel;
         lpg_pkg::MODE_FAST:    emit_level = fast_on_ff ? lpg_pkg::FullLevel : '0;
         lpg_pkg::MODE_SLOW:    emit_level = slow_on_ff ? lpg_pkg::FullLevel : '0;
         lpg_pkg::MODE_ONCE:    emit_level = once_on_ff ? lpg_pkg::FullLevel : '0;
         lpg_pkg::MODE_BREATHE: emit_level = duty_ff;
         default:               emit_level = levels_ff[cnt_ff];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      duty_in       = duty_ff;
      rising_in     = rising_ff;
      fast_accum_in = fast_accum_ff;
      slow_accum_in = slow_accum_ff;
      once_accum_in = once_accum_ff;
      fast_on_in    = fast_on_ff;
      slow_on_in    = slow_on_ff;
      once_on_in    = once_on_ff;
      once_done_in  = once_done_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_num_in    = rsp_num_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;

      mode_we       = 1'b0;
      level_we      = 1'b0;
      wr_idx        = cnt_ff;
      mode_wdata    = lpg_pkg::mode_type'(req_mode);
      level_wdata   = emit_level;

      alu_req.op    = lpg_pkg::ALU_CMP;
      alu_req.a     = '0;
      alu_req.b     = '0;

      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == lpg_pkg::CmdSet) begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = req_led_index;
                  rsp_last_in  = 1'b1;
                  rsp_bad_in   = !set_in_range;
                  rsp_level_in = set_in_range ? set_level : '0;
                  // modes 6 and 7 leave the led as it is
                  if (set_in_range && (req_mode <= lpg_pkg::ModeW'(lpg_pkg::MODE_BREATHE))) begin
                     wr_idx      = set_idx;
                     mode_we     = 1'b1;
                     level_we    = 1'b1;
                     level_wdata = set_level;
                     if (req_mode == lpg_pkg::ModeW'(lpg_pkg::MODE_ONCE)) begin
                        once_on_in    = 1'b1;
                        once_accum_in = '0;
                        once_done_in  = 1'b0;
                     end
                  end
               end else begin
                  state_in = lpg_pkg::ST_BREATHE;
               end
            end
         end
         lpg_pkg::ST_BREATHE: begin
            alu_req.op = rising_ff ? lpg_pkg::ALU_ADD_SAT : lpg_pkg::ALU_SUB_FLOOR;
            alu_req.a  = duty_ff;
            alu_req.b  = breathe_step_ff;
            duty_in    = alu_rsp.res;
            // reverse at either limit
            if ((alu_rsp.res == '0) || (alu_rsp.res == lpg_pkg::FullLevel)) begin
               rising_in = !rising_ff;
            end
            state_in = lpg_pkg::ST_FAST_ADD;
         end
         lpg_pkg::ST_FAST_ADD: begin
            alu_req.op    = lpg_pkg::ALU_ADD_SAT;
            alu_req.a     = fast_accum_ff;
            alu_req.b     = LW'(frame_ms_ff);
            fast_accum_in = alu_rsp.res;
            state_in      = lpg_pkg::ST_FAST_CMP;
         end
         lpg_pkg::ST_FAST_CMP: begin
            alu_req.a = fast_accum_ff;
            alu_req.b = fast_half_ms_ff;
            if (alu_rsp.gt) begin
               fast_on_in    = !fast_on_ff;
               fast_accum_in = '0;
            end
            state_in = lpg_pkg::ST_SLOW_ADD;
         end
         lpg_pkg::ST_SLOW_ADD: begin
            alu_req.op    = lpg_pkg::ALU_ADD_SAT;
            alu_req.a     = slow_accum_ff;
            alu_req.b     = LW'(frame_ms_ff);
            slow_accum_in = alu_rsp.res;
            state_in      = lpg_pkg::ST_SLOW_CMP;
         end
         lpg_pkg::ST_SLOW_CMP: begin
            alu_req.a = slow_accum_ff;
            alu_req.b = slow_half_ms_ff;
            if (alu_rsp.gt) begin
               slow_on_in    = !slow_on_ff;
               slow_accum_in = '0;
            end
            state_in = lpg_pkg::ST_ONCE_ADD;
         end
         lpg_pkg::ST_ONCE_ADD: begin
            alu_req.op    = lpg_pkg::ALU_ADD_SAT;
            alu_req.a     = once_accum_ff;
            alu_req.b     = LW'(frame_ms_ff);
            once_accum_in = alu_rsp.res;
            state_in      = lpg_pkg::ST_ONCE_CMP;
         end
         lpg_pkg::ST_ONCE_CMP: begin
            alu_req.a = once_accum_ff;
            alu_req.b = once_ms_ff;
            if (!once_done_ff && alu_rsp.gt) begin
               once_on_in    = 1'b0;
               once_done_in  = 1'b1;
               once_accum_in = '0;
            end
            cnt_in   = '0;
            state_in = lpg_pkg::ST_EMIT;
         end
         lpg_pkg::ST_EMIT: begin
            if (out_free) begin
               level_we     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_num_in   = lpg_pkg::IndexW'(cnt_ff);
               rsp_level_in = emit_level;
               rsp_last_in  = cnt_at_last;
               rsp_bad_in   = 1'b0;
               if (cnt_at_last) begin
                  state_in = lpg_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = lpg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lpg_pkg::ST_IDLE;
         cnt_ff        <= '0;
         duty_ff       <= '0;
         rising_ff     <= 1'b1;
         fast_accum_ff <= '0;
         slow_accum_ff <= '0;
         once_accum_ff <= '0;
         fast_on_ff    <= 1'b0;
         slow_on_ff    <= 1'b0;
         once_on_ff    <= 1'b0;
         once_done_ff  <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         duty_ff       <= duty_in;
         rising_ff     <= rising_in;
         fast_accum_ff <= fast_accum_in;
         slow_accum_ff <= slow_accum_in;
         once_accum_ff <= once_accum_in;
         fast_on_ff    <= fast_on_in;
         slow_on_ff    <= slow_on_in;
         once_on_ff    <= once_on_in;
         once_done_ff  <= once_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_num_ff   <= rsp_num_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            modes_ff[i]  <= lpg_pkg::MODE_OFF;
            levels_ff[i] <= '0;
         end
      end else begin
         if (mode_we) begin
            modes_ff[wr_idx] <= mode_wdata;
         end
         if (level_we) begin
            levels_ff[wr_idx] <= level_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ms_ff     <= lpg_pkg::FrameMsReset;
         fast_half_ms_ff <= lpg_pkg::FastHalfMsReset;
         slow_half_ms_ff <= lpg_pkg::SlowHalfMsReset;
         once_ms_ff      <= lpg_pkg::OnceMsReset;
         breathe_step_ff <= lpg_pkg::BreatheStepReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lpg_pkg::CSR_FRAME_MS:     frame_ms_ff     <= csr_wdata[lpg_pkg::FrameW-1:0];
            lpg_pkg::CSR_FAST_HALF_MS: fast_half_ms_ff <= csr_wdata;
            lpg_pkg::CSR_SLOW_HALF_MS: slow_half_ms_ff <= csr_wdata;
            lpg_pkg::CSR_ONCE_MS:      once_ms_ff      <= csr_wdata;
            lpg_pkg::CSR_BREATHE_STEP: breathe_step_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // a pending one-shot is the only time its blink may be lit
   a_once_done_dark: assert property (@(posedge clock) disable iff (reset)
      once_done_ff |-> !once_on_ff)
      else $error("one-shot lit while no one-shot is pending");

   // an out-of-range answer is always the only item of its input
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> rsp_last_ff)
      else $error("bad index item without last");

   // an accepted tick starts the timer sequence
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_cmd == lpg_pkg::CmdTick)) |=> (state_ff == lpg_pkg::ST_BREATHE))
      else $error("tick did not start the sequencer");

   // emitting the final led returns to idle
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lpg_pkg::ST_EMIT) && out_free && cnt_at_last)
         |=> ((state_ff == lpg_pkg::ST_IDLE) && rsp_valid_ff && rsp_last_ff))
      else $error("emit sequence did not close with last");

   // emit counter stays inside the led store
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpg_pkg::ST_EMIT) |-> (cnt_ff <= IdxW'(NUM_LEDS - 1)))
      else $error("emit counter out of range");

endmodule

// File: tb/sv/led_pattern_generator_test.sv
// led_pattern_generator_test: self-checking testbench for the led pattern generator
// drives set-mode and tick items, predicts every level report, and checks them in order
// depends on lpg_pkg and led_pattern_generator
`timescale 1ns / 100ps

module led_pattern_generator_test;

   localparam int  LedCount     = lpg_pkg::NumLedsDefault;
   localparam real ClockPeriod  = 10.0;
   localparam int  SettleCycles = 2 * LedCount + 8;
   localparam logic [lpg_pkg::ModeW-1:0] ModeSpareLo = 3'd6;
   localparam logic [lpg_pkg::ModeW-1:0] ModeSpareHi = 3'd7;

   typedef struct packed {
      logic                       cmd;
      logic [lpg_pkg::IndexW-1:0] led_index;
      logic [lpg_pkg::ModeW-1:0]  mode;
   } led_item_type;

   typedef struct packed {
      logic [lpg_pkg::IndexW-1:0] led_number;
      logic [lpg_pkg::LevelW-1:0] level;
      logic                       last;
      logic                       bad_index;
   } level_report_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_cmd = lpg_pkg::CmdTick;
   logic [lpg_pkg::IndexW-1:0]   req_led_index = '0;
   logic [lpg_pkg::ModeW-1:0]    req_mode = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [lpg_pkg::IndexW-1:0]   rsp_led_number;
   logic [lpg_pkg::LevelW-1:0]   rsp_level;
   logic                         rsp_last;
   logic                         rsp_bad_index;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [lpg_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [lpg_pkg::CsrDataW-1:0] csr_wdata = '0;

   led_item_type     pending_items[$];
   level_report_type expected_levels[$];
   led_item_type     next_item;
   logic             req_took = 1'b0;
   int               idle_pct = 16;
   int               items_queued = 0;
   int               items_accepted = 0;
   int               ticks_accepted = 0;
   int               reports_checked = 0;
   int               reg_writes = 0;
   int               error_count = 0;

   // predicted block state
   lpg_pkg::mode_type          led_mode_st[LedCount];
   logic [lpg_pkg::LevelW-1:0] led_level_st[LedCount];
   logic [lpg_pkg::LevelW-1:0] duty;
   logic                       duty_rising;
   logic [lpg_pkg::LevelW-1:0] fast_acc, slow_acc, once_acc;
   logic                       fast_lit, slow_lit, once_lit, once_idle;
   logic [lpg_pkg::FrameW-1:0] frame_ms_cfg;
   logic [lpg_pkg::LevelW-1:0] fast_half_cfg, slow_half_cfg, once_cfg, step_cfg;

   led_pattern_generator #(
      .NUM_LEDS(LedCount)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_led_index (req_led_index),
      .req_mode      (req_mode),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_led_number(rsp_led_number),
      .rsp_level     (rsp_level),
      .rsp_last      (rsp_last),
      .rsp_bad_index (rsp_bad_index),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   function automatic logic [lpg_pkg::LevelW-1:0] sat_sum(
      input logic [lpg_pkg::LevelW-1:0] a,
      input logic [lpg_pkg::LevelW-1:0] b);
      logic [lpg_pkg::LevelW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[lpg_pkg::LevelW] ? lpg_pkg::FullLevel : s[lpg_pkg::LevelW-1:0];
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 50) begin
         $display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      end
      error_count++;
   endtask

   task automatic predict_levels(input led_item_type item);
      level_report_type r;
      logic [lpg_pkg::LevelW-1:0] frame_step;
      int i;
      if (item.cmd == lpg_pkg::CmdSet) begin
         r.led_number = item.led_index;
         r.last = 1'b1;
         r.bad_index = 1'b0;
         if (item.led_index >= LedCount) begin
            r.level = '0;
            r.bad_index = 1'b1;
         end else begin
            // spare modes leave the stored mode and level alone
            if (item.mode <= lpg_pkg::MODE_BREATHE) begin
               led_mode_st[item.led_index] = lpg_pkg::mode_type'(item.mode);
               case (item.mode)
                  lpg_pkg::MODE_OFF: led_level_st[item.led_index] = '0;
                  lpg_pkg::MODE_ON: led_level_st[item.led_index] = lpg_pkg::FullLevel;
                  lpg_pkg::MODE_ONCE: begin
                     led_level_st[item.led_index] = lpg_pkg::FullLevel;
                     once_lit = 1'b1;
                     once_acc = '0;
                     once_idle = 1'b0;
                  end
                  default: ;
               endcase
            end
            r.level = led_level_st[item.led_index];
         end
         expected_levels.push_back(r);
      end else begin
         if (duty_rising) begin
            duty = sat_sum(duty, step_cfg);
         end else begin
            duty = (duty > step_cfg) ? duty - step_cfg : '0;
         end
         // triangle wave turns around at either clamp
         if (duty == lpg_pkg::FullLevel || duty == '0) duty_rising = !duty_rising;
         frame_step = {{(lpg_pkg::LevelW - lpg_pkg::FrameW){1'b0}}, frame_ms_cfg};
         fast_acc = sat_sum(fast_acc, frame_step);
         slow_acc = sat_sum(slow_acc, frame_step);
         once_acc = sat_sum(once_acc, frame_step);
         if (fast_acc > fast_half_cfg) begin
            fast_lit = !fast_lit;
            fast_acc = '0;
         end
         if (slow_acc > slow_half_cfg) begin
            slow_lit = !slow_lit;
            slow_acc = '0;
         end
         if (!once_idle && once_acc > once_cfg) begin
            once_lit = 1'b0;
            once_idle = 1'b1;
            once_acc = '0;
         end
         for (i = 0; i < LedCount; i++) begin
            case (led_mode_st[i])
               lpg_pkg::MODE_OFF: led_level_st[i] = '0;
               lpg_pkg::MODE_ON: led_level_st[i] = lpg_pkg::FullLevel;
               lpg_pkg::MODE_FAST: led_level_st[i] = fast_lit ? lpg_pkg::FullLevel : '0;
               lpg_pkg::MODE_SLOW: led_level_st[i] = slow_lit ? lpg_pkg::FullLevel : '0;
               lpg_pkg::MODE_ONCE: led_level_st[i] = once_lit ? lpg_pkg::FullLevel : '0;
               lpg_pkg::MODE_BREATHE: led_level_st[i] = duty;
               default: ;
            endcase
            r.led_number = lpg_pkg::IndexW'(i);
            r.level = led_level_st[i];
            r.last = (i == LedCount - 1);
            r.bad_index = 1'b0;
            expected_levels.push_back(r);
         end
      end
   endtask

   // request driver and ready toggling, both on the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_item.cmd;
            req_led_index <= next_item.led_index;
            req_mode <= next_item.mode;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: register writes, accepted items and level reports on the rising edge
   always @(posedge clock) begin
      level_report_type want;
      req_took <= req_valid && req_ready;
      if (reset) begin
         for (int i = 0; i < LedCount; i++) begin
            led_mode_st[i] = lpg_pkg::MODE_OFF;
            led_level_st[i] = '0;
         end
         duty = '0;
         duty_rising = 1'b1;
         fast_acc = '0;
         slow_acc = '0;
         once_acc = '0;
         fast_lit = 1'b0;
         slow_lit = 1'b0;
         once_lit = 1'b0;
         once_idle = 1'b1;
         frame_ms_cfg = lpg_pkg::FrameMsReset;
         fast_half_cfg = lpg_pkg::FastHalfMsReset;
         slow_half_cfg = lpg_pkg::SlowHalfMsReset;
         once_cfg = lpg_pkg::OnceMsReset;
         step_cfg = lpg_pkg::BreatheStepReset;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lpg_pkg::CSR_FRAME_MS: frame_ms_cfg = csr_wdata[lpg_pkg::FrameW-1:0];
               lpg_pkg::CSR_FAST_HALF_MS: fast_half_cfg = csr_wdata;
               lpg_pkg::CSR_SLOW_HALF_MS: slow_half_cfg = csr_wdata;
               lpg_pkg::CSR_ONCE_MS: once_cfg = csr_wdata;
               lpg_pkg::CSR_BREATHE_STEP: step_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_levels(led_item_type'({req_cmd, req_led_index, req_mode}));
            items_accepted++;
            if (req_cmd == lpg_pkg::CmdTick) ticks_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("item with nothing pending, led_number", rsp_led_number, -1);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_led_number !== want.led_number)
                  report_mismatch("led_number", rsp_led_number, want.led_number);
               if (rsp_level !== want.level)
                  report_mismatch("level", rsp_level, want.level);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
               if (rsp_bad_index !== want.bad_index)
                  report_mismatch("bad_index", rsp_bad_index, want.bad_index);
               reports_checked++;
            end
         end
      end
   end

   task automatic queue_item(input logic cmd, input logic [lpg_pkg::IndexW-1:0] idx,
                             input logic [lpg_pkg::ModeW-1:0] mode);
      pending_items.push_back('{cmd: cmd, led_index: idx, mode: mode});
      items_queued++;
   endtask

   task automatic queue_random(input int count, input int tick_pct);
      logic [lpg_pkg::IndexW-1:0] idx;
      logic [lpg_pkg::ModeW-1:0]  mode;
      logic                       cmd;
      repeat (count) begin
         // mostly valid LEDs and named modes, now and then anything the fields hold
         idx = ($urandom_range(99) < 85) ? lpg_pkg::IndexW'($urandom_range(LedCount - 1))
                                         : lpg_pkg::IndexW'($urandom_range(255));
         mode = ($urandom_range(99) < 85)
                ? lpg_pkg::ModeW'($urandom_range(lpg_pkg::MODE_BREATHE))
                : lpg_pkg::ModeW'($urandom_range(7));
         cmd = ($urandom_range(99) < tick_pct) ? lpg_pkg::CmdTick : lpg_pkg::CmdSet;
         queue_item(cmd, idx, mode);
      end
   endtask

   task automatic write_reg(input lpg_pkg::csr_index_type idx,
                            input logic [lpg_pkg::CsrDataW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic set_config(input logic [lpg_pkg::CsrDataW-1:0] frame,
                             input logic [lpg_pkg::CsrDataW-1:0] fast,
                             input logic [lpg_pkg::CsrDataW-1:0] slow,
                             input logic [lpg_pkg::CsrDataW-1:0] once,
                             input logic [lpg_pkg::CsrDataW-1:0] step);
      write_reg(lpg_pkg::CSR_FRAME_MS, frame);
      write_reg(lpg_pkg::CSR_FAST_HALF_MS, fast);
      write_reg(lpg_pkg::CSR_SLOW_HALF_MS, slow);
      write_reg(lpg_pkg::CSR_ONCE_MS, once);
      write_reg(lpg_pkg::CSR_BREATHE_STEP, step);
   endtask

   // sender holds off until every accepted item has been answered
   task automatic drain();
      while (items_accepted != items_queued || expected_levels.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every mode, both index extremes, out of range and spare modes
      queue_item(lpg_pkg::CmdSet, 8'd0, lpg_pkg::MODE_ON);
      queue_item(lpg_pkg::CmdSet, 8'd1, lpg_pkg::MODE_FAST);
      queue_item(lpg_pkg::CmdSet, 8'd2, lpg_pkg::MODE_SLOW);
      queue_item(lpg_pkg::CmdSet, 8'd3, lpg_pkg::MODE_BREATHE);
      queue_item(lpg_pkg::CmdSet, 8'd4, lpg_pkg::MODE_OFF);
      queue_item(lpg_pkg::CmdSet, 8'd5, lpg_pkg::MODE_ON);
      queue_item(lpg_pkg::CmdSet, lpg_pkg::IndexW'(LedCount - 1), lpg_pkg::MODE_ONCE);
      queue_item(lpg_pkg::CmdSet, lpg_pkg::IndexW'(LedCount), lpg_pkg::MODE_ON);
      queue_item(lpg_pkg::CmdSet, 8'd255, ModeSpareHi);
      queue_item(lpg_pkg::CmdSet, 8'd6, ModeSpareLo);
      queue_item(lpg_pkg::CmdSet, 8'd0, ModeSpareHi);
      queue_item(lpg_pkg::CmdTick, 8'd0, lpg_pkg::MODE_OFF);
      queue_item(lpg_pkg::CmdTick, 8'd255, ModeSpareHi);
      queue_item(lpg_pkg::CmdTick, 8'd85, lpg_pkg::MODE_BREATHE);
      queue_item(lpg_pkg::CmdTick, 8'd170, lpg_pkg::MODE_ONCE);
      queue_item(lpg_pkg::CmdTick, 8'd15, lpg_pkg::MODE_ON);
      queue_item(lpg_pkg::CmdTick, 8'd240, ModeSpareLo);
      queue_item(lpg_pkg::CmdSet, 8'd5, lpg_pkg::MODE_OFF);
      queue_item(lpg_pkg::CmdSet, 8'd0, lpg_pkg::MODE_ONCE);
      queue_item(lpg_pkg::CmdTick, 8'd1, lpg_pkg::MODE_FAST);
      queue_item(lpg_pkg::CmdSet, 8'd128, lpg_pkg::MODE_SLOW);
      queue_item(lpg_pkg::CmdTick, 8'd127, lpg_pkg::MODE_SLOW);
      drain();

      queue_random(60, 40);
      drain();

      // fast timers, full breathe steps, and a stretch with no idling
      set_config(16'd1000, 16'd0, 16'd1500, 16'd2500, 16'd65535);
      idle_pct = 0;
      queue_random(55, 50);
      drain();
      idle_pct = 16;

      set_config(16'd1, 16'd0, 16'd1, 16'd0, 16'd1);
      queue_random(45, 40);
      drain();

      // masked frame width, timers that never expire, zero breathe step
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      queue_random(80, 90);
      drain();

      set_config(16'd0,
                 lpg_pkg::CsrDataW'($urandom_range(3000)),
                 lpg_pkg::CsrDataW'($urandom_range(65535)),
                 lpg_pkg::CsrDataW'($urandom_range(3000)),
                 lpg_pkg::CsrDataW'($urandom_range(1, 40000)));
      queue_random(50, 40);
      drain();

      $display("covered %0d items (%0d ticks) and %0d level reports over %0d register writes",
               items_accepted, ticks_accepted, reports_checked, reg_writes);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d level reports still pending", expected_levels.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
src/lpg_pkg.sv
src/lpg_alu.sv
src/led_pattern_generator.sv
tb/sv/led_pattern_generator_test.sv
